[rtl/core/bitps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix-sum tree package
// Field widths, stream packing and sequencer states shared by the
// binary indexed tree prefix-sum block and its node memory.
// ----------------------------------------------------------------------------
package bitps_pkg;

    // Default number of tree elements
    localparam int TREE_SIZE_DEF = 1024;

    // Payload field widths
    localparam int POS_W     = 11;
    localparam int DELTA_W   = 32;
    localparam int SUM_W     = 48;

    // Stream packing
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // Operation codes carried in s_axis_tuser
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

endpackage

[rtl/core/bitps_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node sum memory
// Single write port and single registered read port for the tree nodes.
// ----------------------------------------------------------------------------
module bitps_ram #(
    parameter int DEPTH  = bitps_pkg::TREE_SIZE_DEF,
    parameter int WIDTH  = bitps_pkg::SUM_W,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);
    import bitps_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/binary_indexed_tree_prefix_sum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary indexed tree prefix sum
// Point add and prefix query over TREE_SIZE signed 48-bit counters.
// ----------------------------------------------------------------------------
// The lowbit chain holds 0 .. log2(TREE_SIZE)+1 nodes (11 at 1024). The
// memory port visits one node per cycle and the shared 48-bit adder folds
// the previous node's read data; a new item is accepted only after the
// previous result has been handed to the output register.
// Reset: after aresetn the node memory is cleared in a pass over all
// TREE_SIZE nodes, during which s_axis_tready stays low.
// ----------------------------------------------------------------------------
module binary_indexed_tree_prefix_sum #(
    parameter int TREE_SIZE = bitps_pkg::TREE_SIZE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [10:0] position, [42:11] delta_value, [47:43] zero
    input  logic [bitps_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] opcode
    input  logic [bitps_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [47:0] prefix_total
    output logic [bitps_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [0] range_error
    output logic [bitps_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
    import bitps_pkg::*;

    localparam int ADDR_W = $clog2(TREE_SIZE);
    localparam int CNT_W  = (ADDR_W + 2 > POS_W + 1) ? ADDR_W + 2 : POS_W + 1;
    localparam logic [CNT_W-1:0]  SIZE_C  = CNT_W'(TREE_SIZE);
    localparam logic [ADDR_W-1:0] LAST_AD = ADDR_W'(TREE_SIZE - 1);

    // Sequencer and walk state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]    node_reg, node_next;
    logic                query_reg, query_next;
    logic                err_reg, err_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   wa_reg, wa_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [SUM_W-1:0]    delta_reg, delta_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]    m_total_reg, m_total_next;
    logic                m_err_reg, m_err_next;

    // Memory port
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [SUM_W-1:0]    ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [SUM_W-1:0]    ram_rd_data;

    // Input unpacking
    logic [POS_W-1:0]    in_pos;
    logic [DELTA_W-1:0]  in_delta;
    logic [CNT_W-1:0]    in_pos_ext;
    logic                in_accept;

    // Walk helpers
    logic                node_ok;
    logic [CNT_W-1:0]    node_low;
    logic [CNT_W-1:0]    node_minus1;
    logic [SUM_W-1:0]    add_a;
    logic [SUM_W-1:0]    add_sum;
    logic                out_free;

    assign in_pos     = s_axis_tdata[POS_W-1:0];
    assign in_delta   = s_axis_tdata[POS_W+DELTA_W-1:POS_W];
    assign in_pos_ext = {{(CNT_W-POS_W){1'b0}}, in_pos};
    assign in_accept  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Lowbit chain step: up for an add, down for a query
    assign node_minus1 = node_reg - CNT_W'(1);
    assign node_low    = node_reg & ~node_minus1;
    assign node_ok     = query_reg ? (node_reg != '0) : (node_reg <= SIZE_C);

    // Shared adder: node plus delta for an add, running total plus node for a query
    assign add_a   = query_reg ? acc_reg : delta_reg;
    assign add_sum = add_a + ram_rd_data;

    // Memory port control
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = wa_reg;
        ram_wr_data = add_sum;
        ram_rd_en   = 1'b0;
        ram_rd_addr = node_minus1[ADDR_W-1:0];
        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
            end
            ST_WALK: begin
                ram_wr_en = pend_reg && !query_reg;
                ram_rd_en = node_ok;
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        node_next    = node_reg;
        query_next   = query_reg;
        err_next     = err_reg;
        pend_next    = 1'b0;
        wa_next      = wa_reg;
        acc_next     = acc_reg;
        delta_next   = delta_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_total_next = m_total_reg;
        m_err_next   = m_err_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_AD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    query_next = (s_axis_tuser[0] == OP_QUERY);
                    delta_next = {{(SUM_W-DELTA_W){in_delta[DELTA_W-1]}}, in_delta};
                    acc_next   = '0;
                    state_next = ST_WALK;
                    if (s_axis_tuser[0] == OP_QUERY) begin
                        // saturate an oversized query bound
                        err_next  = (in_pos_ext > SIZE_C);
                        node_next = (in_pos_ext > SIZE_C) ? SIZE_C : in_pos_ext;
                    end else begin
                        // an index past the end gives a chain with no nodes
                        err_next  = (in_pos_ext >= SIZE_C);
                        node_next = in_pos_ext + CNT_W'(1);
                    end
                end
            end
            ST_WALK: begin
                // fold the node read in the previous cycle
                if (pend_reg && query_reg) begin
                    acc_next = add_sum;
                end
                // issue the next node or finish
                if (node_ok) begin
                    pend_next = 1'b1;
                    wa_next   = node_minus1[ADDR_W-1:0];
                    node_next = query_reg ? (node_reg & node_minus1)
                                          : (node_reg + node_low);
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_total_next = query_reg ? acc_reg : '0;
                    m_err_next   = err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        node_reg    <= node_next;
        query_reg   <= query_next;
        err_reg     <= err_next;
        wa_reg      <= wa_next;
        acc_reg     <= acc_next;
        delta_reg   <= delta_next;
        m_total_reg <= m_total_next;
        m_err_reg   <= m_err_next;
    end

    bitps_ram #(
        .DEPTH  (TREE_SIZE),
        .WIDTH  (SUM_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_total_reg;
    assign m_axis_tuser  = m_err_reg;

    // A result appears only from the finishing state
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the finishing state");

    // A pending read is folded only while walking
    a_pend_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == ST_WALK))
        else $error("pending node read outside the walk");

    // Memory writes stay inside the tree
    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (ram_wr_addr <= LAST_AD))
        else $error("node write beyond the tree");

endmodule
